/* hw/rtl/gls_pkg.sv */
// Shared types and constants of the grid line side classifier.
package gls_pkg;

    localparam int ANGLE_W  = 16;
    localparam int STEP_W   = 15;
    localparam int MARGIN_W = 11;
    localparam int INDEX_W  = 5;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // area magnitudes at or above 2^29 always count as clear of the band
    localparam int SQ_CLAMP_W = 29;

    localparam logic [ANGLE_W-1:0]  YAW_ORIGIN_RST   = 16'hF800;
    localparam logic [STEP_W-1:0]   YAW_STEP_RST     = 15'd1024;
    localparam logic [ANGLE_W-1:0]  PITCH_ORIGIN_RST = 16'd819;
    localparam logic [STEP_W-1:0]   PITCH_STEP_RST   = 15'd256;
    localparam logic [MARGIN_W-1:0] MARGIN_RST       = 11'd20;

    typedef enum logic [1:0] {
        STRAT_ATTACK  = 2'd0,
        STRAT_DEFENCE = 2'd1,
        STRAT_CALM    = 2'd2
    } t_strategy;

    typedef enum logic {
        CMD_LOAD     = 1'b0,
        CMD_CLASSIFY = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        REG_YAW_ORIGIN   = 3'd0,
        REG_YAW_STEP     = 3'd1,
        REG_PITCH_ORIGIN = 3'd2,
        REG_PITCH_STEP   = 3'd3,
        REG_MARGIN       = 3'd4
    } t_reg_index;

endpackage

/* hw/rtl/gls_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
module gls_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hw/rtl/grid_line_side_classifier.sv */
// Top level of the grid line side classifier: config registers and full pipeline.
//
//  channel  | dir | handshake                    | contents
//  ---------+-----+------------------------------+------------------------------------------
//  s_axis   | in  | tvalid/tready                | tuser: command; tdata: load or classify
//  m_axis   | out | tvalid/tready                | tdata: strategy and interpolated line
//  apb      | in  | psel/penable/pwrite, pready  | five config registers at 4*index
//
// One transaction enters per cycle while m_axis is not stalled. A classify transaction passes
// stages A to H, M and the output register before it leaves; the rounding divider, two result
// bits per stage, spans ceil(COORD_BITS/2) stages. Load transactions write the table three
// stages in and produce no output. Reset is synchronous and clears valid bits and config
// registers; the table is undefined until loaded. A stall on m_axis freezes every stage at
// once and drops s_axis_tready, so nothing is lost or repeated.
module grid_line_side_classifier #(
    parameter int GRID_ROWS  = 5,
    parameter int GRID_COLS  = 5,
    parameter int COORD_BITS = 12,
    localparam int IN_BITS   = 37 + 6 * COORD_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 2 + 4 * COORD_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // grid_index, first_x, first_y, second_x, second_y, yaw, pitch, ball_x, ball_y
    input  logic [IN_W-1:0]            s_axis_tdata,
    // command
    input  logic [0:0]                 s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // strategy, line_start_x, line_start_y, line_end_x, line_end_y
    output logic [OUT_W-1:0]           m_axis_tdata,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gls_pkg::APB_AW-1:0] paddr,
    input  logic [gls_pkg::APB_DW-1:0] pwdata,
    output logic [gls_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    import gls_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int ENTRIES  = GRID_ROWS * GRID_COLS;
    localparam int AW       = $clog2(ENTRIES);
    localparam int QC       = $clog2(GRID_COLS);
    localparam int QR       = $clog2(GRID_ROWS);
    localparam int LIMC_W   = STEP_W + QC;
    localparam int LIMR_W   = STEP_W + QR;
    localparam int REMC_W   = ANGLE_W + QC;
    localparam int REMR_W   = ANGLE_W + QR;
    localparam int WT_W     = 2 * STEP_W;
    localparam int MAG_W    = C + WT_W;
    localparam int NUM_W    = MAG_W + 2;
    localparam int DIV_STG  = (C + 1) / 2;
    localparam int COMPS    = 4;
    localparam int TAPS     = 4;
    localparam int LANES    = COMPS * TAPS;
    localparam int SUM_W    = C + 3;
    localparam int V_W      = C + 1;
    localparam int PROD_W   = 2 * V_W;
    localparam int AREA_W   = PROD_W + 1;
    localparam int ABS_W    = PROD_W;
    localparam int SQ_W     = (ABS_W < SQ_CLAMP_W) ? ABS_W : SQ_CLAMP_W;
    localparam int ASQ_W    = 2 * SQ_W;
    localparam int MSQ_W    = 2 * MARGIN_W;
    localparam int RHS_W    = MSQ_W + PROD_W;
    localparam int CMP_W    = (ASQ_W > RHS_W) ? ASQ_W : RHS_W;

    // tdata field offsets, lowest field first
    localparam int OFF_FX    = INDEX_W;
    localparam int OFF_YAW   = INDEX_W + 4 * C;
    localparam int OFF_PITCH = OFF_YAW + ANGLE_W;
    localparam int OFF_BX    = OFF_PITCH + ANGLE_W;
    localparam int OFF_BY    = OFF_BX + C;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (C - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    // Side data that rides along with each transaction from stage A to stage M.
    typedef struct packed {
        logic         byp;
        t_strategy    strat;
        logic [C-1:0] bx;
        logic [C-1:0] by;
    } t_side;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]  r_yaw_origin;
    logic [STEP_W-1:0]   r_yaw_step;
    logic [ANGLE_W-1:0]  r_pitch_origin;
    logic [STEP_W-1:0]   r_pitch_step;
    logic [MARGIN_W-1:0] r_margin;
    logic                cfg_wr;
    t_reg_index          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_index'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_origin   <= YAW_ORIGIN_RST;
            r_yaw_step     <= YAW_STEP_RST;
            r_pitch_origin <= PITCH_ORIGIN_RST;
            r_pitch_step   <= PITCH_STEP_RST;
            r_margin       <= MARGIN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_YAW_ORIGIN:   r_yaw_origin   <= pwdata[ANGLE_W-1:0];
                REG_YAW_STEP:     r_yaw_step     <= pwdata[STEP_W-1:0];
                REG_PITCH_ORIGIN: r_pitch_origin <= pwdata[ANGLE_W-1:0];
                REG_PITCH_STEP:   r_pitch_step   <= pwdata[STEP_W-1:0];
                REG_MARGIN:       r_margin       <= pwdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_YAW_ORIGIN:   prdata = APB_DW'(r_yaw_origin);
            REG_YAW_STEP:     prdata = APB_DW'(r_yaw_step);
            REG_PITCH_ORIGIN: prdata = APB_DW'(r_pitch_origin);
            REG_PITCH_STEP:   prdata = APB_DW'(r_pitch_step);
            REG_MARGIN:       prdata = APB_DW'(r_margin);
            default:          prdata = '0;
        endcase
    end

    // a zero step behaves as a step of one
    logic [STEP_W-1:0] ys_eff;
    logic [STEP_W-1:0] ps_eff;
    assign ys_eff = (r_yaw_step == '0) ? STEP_W'(1) : r_yaw_step;
    assign ps_eff = (r_pitch_step == '0) ? STEP_W'(1) : r_pitch_step;

    // ------------------------------------------------------------------
    // Global advance: every stage moves together unless the output is stuck
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic en;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage A: place the head angles against the grid, pick bypass cases
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] in_yaw;
    logic [ANGLE_W-1:0] in_pitch;
    logic [ANGLE_W:0]   a_dy;
    logic [ANGLE_W:0]   a_dp;
    logic [LIMC_W-1:0]  a_ylim;
    logic [LIMR_W-1:0]  a_plim;
    logic               a_over_y;
    logic               a_over_p;
    logic               a_byp;
    t_strategy          a_strat;

    assign in_yaw   = s_axis_tdata[OFF_YAW +: ANGLE_W];
    assign in_pitch = s_axis_tdata[OFF_PITCH +: ANGLE_W];
    assign a_dy     = {in_yaw[ANGLE_W-1], in_yaw} - {r_yaw_origin[ANGLE_W-1], r_yaw_origin};
    assign a_dp     = {in_pitch[ANGLE_W-1], in_pitch}
                    - {r_pitch_origin[ANGLE_W-1], r_pitch_origin};
    assign a_ylim   = LIMC_W'(GRID_COLS - 1) * LIMC_W'(ys_eff);
    assign a_plim   = LIMR_W'(GRID_ROWS - 1) * LIMR_W'(ps_eff);
    assign a_over_y = 32'(a_dy[ANGLE_W-1:0]) > 32'(a_ylim);
    assign a_over_p = 32'(a_dp[ANGLE_W-1:0]) > 32'(a_plim);

    always_comb begin
        priority if (a_dy[ANGLE_W]) begin
            a_byp   = 1'b1;
            a_strat = STRAT_ATTACK;
        end else if (a_over_y) begin
            a_byp   = 1'b1;
            a_strat = STRAT_DEFENCE;
        end else if (a_dp[ANGLE_W] || a_over_p) begin
            a_byp   = 1'b1;
            a_strat = STRAT_CALM;
        end else begin
            a_byp   = 1'b0;
            a_strat = STRAT_CALM;
        end
    end

    logic               r_a_valid;
    t_command           r_a_cmd;
    logic [INDEX_W-1:0] r_a_idx;
    logic [4*C-1:0]     r_a_entry;
    t_side              r_a_side;
    logic [ANGLE_W-1:0] r_a_dy;
    logic [ANGLE_W-1:0] r_a_dp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_axis_tvalid;
        end
        if (en) begin
            r_a_cmd        <= t_command'(s_axis_tuser[0]);
            r_a_idx        <= s_axis_tdata[INDEX_W-1:0];
            r_a_entry      <= s_axis_tdata[OFF_FX +: 4*C];
            r_a_side.byp   <= a_byp;
            r_a_side.strat <= a_strat;
            r_a_side.bx    <= s_axis_tdata[OFF_BX +: C];
            r_a_side.by    <= s_axis_tdata[OFF_BY +: C];
            r_a_dy         <= a_dy[ANGLE_W-1:0];
            r_a_dp         <= a_dp[ANGLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: grid cell and remainder, short restoring divides
    // ------------------------------------------------------------------
    logic [REMC_W-1:0] b_rem_c;
    logic [REMC_W-1:0] b_trial_c;
    logic [REMR_W-1:0] b_rem_r;
    logic [REMR_W-1:0] b_trial_r;
    logic [QC-1:0]     b_jl;
    logic [QR-1:0]     b_il;

    always_comb begin
        b_rem_c = REMC_W'(r_a_dy);
        b_jl    = '0;
        for (int k = QC - 1; k >= 0; k--) begin
            b_trial_c = REMC_W'(ys_eff) << k;
            if (b_rem_c >= b_trial_c) begin
                b_rem_c = b_rem_c - b_trial_c;
                b_jl[k] = 1'b1;
            end
        end
        b_rem_r = REMR_W'(r_a_dp);
        b_il    = '0;
        for (int k = QR - 1; k >= 0; k--) begin
            b_trial_r = REMR_W'(ps_eff) << k;
            if (b_rem_r >= b_trial_r) begin
                b_rem_r = b_rem_r - b_trial_r;
                b_il[k] = 1'b1;
            end
        end
    end

    logic               r_b_valid;
    t_command           r_b_cmd;
    logic [INDEX_W-1:0] r_b_idx;
    logic [4*C-1:0]     r_b_entry;
    t_side              r_b_side;
    logic [QC-1:0]      r_b_jl;
    logic [QR-1:0]      r_b_il;
    logic [STEP_W-1:0]  r_b_rj;
    logic [STEP_W-1:0]  r_b_ri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
        if (en) begin
            r_b_cmd   <= r_a_cmd;
            r_b_idx   <= r_a_idx;
            r_b_entry <= r_a_entry;
            r_b_side  <= r_a_side;
            r_b_jl    <= b_jl;
            r_b_il    <= b_il;
            r_b_rj    <= b_rem_c[STEP_W-1:0];
            r_b_ri    <= b_rem_r[STEP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: table access (loads write here, classifies read four corners)
    // and the bilinear weights
    // ------------------------------------------------------------------
    logic          c_use;
    logic [QC-1:0] c_jl;
    logic [QC-1:0] c_jh;
    logic [QR-1:0] c_il;
    logic [QR-1:0] c_ih;
    logic [AW-1:0] c_addr [TAPS];
    logic          c_we;
    logic [STEP_W-1:0] c_wa;
    logic [STEP_W-1:0] c_ua;
    logic [WT_W-1:0]   c_w [TAPS];
    logic [4*C-1:0]    c_rd [TAPS];

    // cells of bypassed or load transactions are meaningless; hold them at the origin
    assign c_use = r_b_valid && (r_b_cmd == CMD_CLASSIFY) && !r_b_side.byp;
    assign c_jl  = c_use ? r_b_jl : '0;
    assign c_il  = c_use ? r_b_il : '0;
    assign c_jh  = (32'(c_jl) >= GRID_COLS - 1) ? QC'(GRID_COLS - 1) : c_jl + QC'(1);
    assign c_ih  = (32'(c_il) >= GRID_ROWS - 1) ? QR'(GRID_ROWS - 1) : c_il + QR'(1);

    assign c_addr[0] = AW'(32'(c_il) * GRID_COLS + 32'(c_jl));
    assign c_addr[1] = AW'(32'(c_il) * GRID_COLS + 32'(c_jh));
    assign c_addr[2] = AW'(32'(c_ih) * GRID_COLS + 32'(c_jl));
    assign c_addr[3] = AW'(32'(c_ih) * GRID_COLS + 32'(c_jh));

    // drop loads aimed past the last entry
    assign c_we = en && r_b_valid && (r_b_cmd == CMD_LOAD)
               && (32'(r_b_idx) < ENTRIES);

    gls_ram #(
        .WIDTH (4 * C),
        .DEPTH (ENTRIES)
    ) u_ram_near (
        .i_clk     (i_clk),
        .i_we      (c_we),
        .i_waddr   (AW'(r_b_idx)),
        .i_wdata   (r_b_entry),
        .i_re      (en),
        .i_raddr_a (c_addr[0]),
        .i_raddr_b (c_addr[1]),
        .o_rdata_a (c_rd[0]),
        .o_rdata_b (c_rd[1])
    );

    gls_ram #(
        .WIDTH (4 * C),
        .DEPTH (ENTRIES)
    ) u_ram_far (
        .i_clk     (i_clk),
        .i_we      (c_we),
        .i_waddr   (AW'(r_b_idx)),
        .i_wdata   (r_b_entry),
        .i_re      (en),
        .i_raddr_a (c_addr[2]),
        .i_raddr_b (c_addr[3]),
        .o_rdata_a (c_rd[2]),
        .o_rdata_b (c_rd[3])
    );

    // (ps-ri)(ys-rj), (ps-ri)rj, ri(ys-rj), ri*rj: an exact node gets the full weight ys*ps
    assign c_wa   = ps_eff - r_b_ri;
    assign c_ua   = ys_eff - r_b_rj;
    assign c_w[0] = WT_W'(c_wa) * WT_W'(c_ua);
    assign c_w[1] = WT_W'(c_wa) * WT_W'(r_b_rj);
    assign c_w[2] = WT_W'(r_b_ri) * WT_W'(c_ua);
    assign c_w[3] = WT_W'(r_b_ri) * WT_W'(r_b_rj);

    logic            r_c_valid;
    t_side           r_c_side;
    logic [WT_W-1:0] r_c_w [TAPS];
    logic [WT_W-1:0] r_c_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid && (r_b_cmd == CMD_CLASSIFY);
        end
        if (en) begin
            r_c_side <= r_b_side;
            r_c_w    <= c_w;
            r_c_d    <= WT_W'(ys_eff) * WT_W'(ps_eff);
        end
    end

    // ------------------------------------------------------------------
    // Stage D: weighted corner terms as sign and magnitude
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] d_mag [LANES];
    logic [LANES-1:0] d_sgn;

    always_comb begin
        logic [C-1:0] coord;
        logic [C-1:0] mag;
        for (int cc = 0; cc < COMPS; cc++) begin
            for (int k = 0; k < TAPS; k++) begin
                coord = c_rd[k][cc*C +: C];
                mag   = coord[C-1] ? (~coord + C'(1)) : coord;
                d_sgn[cc*TAPS + k] = coord[C-1];
                d_mag[cc*TAPS + k] = MAG_W'(mag) * MAG_W'(r_c_w[k]);
            end
        end
    end

    logic             r_d_valid;
    t_side            r_d_side;
    logic [MAG_W-1:0] r_d_mag [LANES];
    logic [LANES-1:0] r_d_sgn;
    logic [WT_W-1:0]  r_d_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
        if (en) begin
            r_d_side <= r_c_side;
            r_d_mag  <= d_mag;
            r_d_sgn  <= d_sgn;
            r_d_d    <= r_c_d;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: rounding divide, q = floor((2|c*w| + D) / 2D), two bits a stage
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] r_e_rem   [DIV_STG][LANES];
    logic [C-1:0]     r_e_q     [DIV_STG][LANES];
    logic [LANES-1:0] r_e_sgn   [DIV_STG];
    logic [WT_W:0]    r_e_den   [DIV_STG];
    logic             r_e_valid [DIV_STG];
    t_side            r_e_side  [DIV_STG];

    for (genvar s = 0; s < DIV_STG; s++) begin : g_div
        logic [NUM_W-1:0] in_rem [LANES];
        logic [C-1:0]     in_q   [LANES];
        logic [LANES-1:0] in_sgn;
        logic [WT_W:0]    in_den;
        logic             in_valid;
        t_side            in_side;
        logic [NUM_W-1:0] n_rem  [LANES];
        logic [C-1:0]     n_q    [LANES];

        if (s == 0) begin : g_head
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    in_rem[l] = NUM_W'({r_d_mag[l], 1'b0}) + NUM_W'(r_d_d);
                    in_q[l]   = '0;
                end
                in_sgn   = r_d_sgn;
                in_den   = {r_d_d, 1'b0};
                in_valid = r_d_valid;
                in_side  = r_d_side;
            end
        end else begin : g_body
            always_comb begin
                in_rem   = r_e_rem[s-1];
                in_q     = r_e_q[s-1];
                in_sgn   = r_e_sgn[s-1];
                in_den   = r_e_den[s-1];
                in_valid = r_e_valid[s-1];
                in_side  = r_e_side[s-1];
            end
        end

        always_comb begin
            logic [NUM_W-1:0] trial;
            int               pos;
            n_rem = in_rem;
            n_q   = in_q;
            for (int b = 0; b < 2; b++) begin
                pos = C - 1 - 2 * s - b;
                if (pos >= 0) begin
                    trial = NUM_W'(in_den) << pos;
                    for (int l = 0; l < LANES; l++) begin
                        if (n_rem[l] >= trial) begin
                            n_rem[l]    = n_rem[l] - trial;
                            n_q[l][pos] = 1'b1;
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_e_valid[s] <= 1'b0;
            end else if (en) begin
                r_e_valid[s] <= in_valid;
            end
            if (en) begin
                r_e_rem[s]  <= n_rem;
                r_e_q[s]    <= n_q;
                r_e_sgn[s]  <= in_sgn;
                r_e_den[s]  <= in_den;
                r_e_side[s] <= in_side;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage F: sum the four rounded terms per coordinate and saturate
    // ------------------------------------------------------------------
    logic signed [C-1:0] f_line [COMPS];

    always_comb begin
        logic signed [SUM_W-1:0] term;
        logic signed [SUM_W-1:0] sum;
        for (int cc = 0; cc < COMPS; cc++) begin
            sum = '0;
            for (int k = 0; k < TAPS; k++) begin
                term = signed'(SUM_W'(r_e_q[DIV_STG-1][cc*TAPS + k]));
                if (r_e_sgn[DIV_STG-1][cc*TAPS + k]) begin
                    term = -term;
                end
                sum = sum + term;
            end
            priority if (sum > SAT_HI) begin
                f_line[cc] = SAT_HI[C-1:0];
            end else if (sum < SAT_LO) begin
                f_line[cc] = SAT_LO[C-1:0];
            end else begin
                f_line[cc] = sum[C-1:0];
            end
        end
    end

    logic                r_f_valid;
    t_side               r_f_side;
    logic signed [C-1:0] r_f_line [COMPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid[DIV_STG-1];
        end
        if (en) begin
            r_f_side <= r_e_side[DIV_STG-1];
            r_f_line <= f_line;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: line and ball vectors from the end point, cross and dot products
    // ------------------------------------------------------------------
    logic signed [V_W-1:0] g_v1x;
    logic signed [V_W-1:0] g_v1y;
    logic signed [V_W-1:0] g_v2x;
    logic signed [V_W-1:0] g_v2y;

    assign g_v1x = V_W'(r_f_line[0]) - V_W'(r_f_line[2]);
    assign g_v1y = V_W'(r_f_line[1]) - V_W'(r_f_line[3]);
    assign g_v2x = V_W'(signed'(r_f_side.bx)) - V_W'(r_f_line[2]);
    assign g_v2y = V_W'(signed'(r_f_side.by)) - V_W'(r_f_line[3]);

    logic                     r_g_valid;
    t_side                    r_g_side;
    logic signed [C-1:0]      r_g_line [COMPS];
    logic signed [PROD_W-1:0] r_g_p1;
    logic signed [PROD_W-1:0] r_g_p2;
    logic signed [PROD_W-1:0] r_g_s1;
    logic signed [PROD_W-1:0] r_g_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= r_f_valid;
        end
        if (en) begin
            r_g_side <= r_f_side;
            r_g_line <= r_f_line;
            r_g_p1   <= PROD_W'(g_v1x) * PROD_W'(g_v2y);
            r_g_p2   <= PROD_W'(g_v2x) * PROD_W'(g_v1y);
            r_g_s1   <= PROD_W'(g_v1x) * PROD_W'(g_v1x);
            r_g_s2   <= PROD_W'(g_v1y) * PROD_W'(g_v1y);
        end
    end

    // ------------------------------------------------------------------
    // Stage H: signed area and squared length, margin squared
    // ------------------------------------------------------------------
    logic                     r_h_valid;
    t_side                    r_h_side;
    logic signed [C-1:0]      r_h_line [COMPS];
    logic signed [AREA_W-1:0] r_h_area;
    logic [PROD_W-1:0]        r_h_len2;
    logic [MSQ_W-1:0]         r_h_msq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (en) begin
            r_h_valid <= r_g_valid;
        end
        if (en) begin
            r_h_side <= r_g_side;
            r_h_line <= r_g_line;
            r_h_area <= AREA_W'(r_g_p1) - AREA_W'(r_g_p2);
            r_h_len2 <= unsigned'(r_g_s1 + r_g_s2);
            r_h_msq  <= MSQ_W'(r_margin) * MSQ_W'(r_margin);
        end
    end

    // ------------------------------------------------------------------
    // Stage M: area squared against margin squared times length squared
    // ------------------------------------------------------------------
    logic [AREA_W-1:0] m_abs_full;
    logic [ABS_W-1:0]  m_abs;
    logic              m_big;

    assign m_abs_full = r_h_area[AREA_W-1] ? unsigned'(-r_h_area) : unsigned'(r_h_area);
    assign m_abs      = m_abs_full[ABS_W-1:0];
    assign m_big      = (m_abs >> SQ_CLAMP_W) != '0;

    logic                r_m_valid;
    t_side               r_m_side;
    logic signed [C-1:0] r_m_line [COMPS];
    logic                r_m_neg;
    logic                r_m_big;
    logic [ASQ_W-1:0]    r_m_asq;
    logic [RHS_W-1:0]    r_m_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_h_valid;
        end
        if (en) begin
            r_m_side <= r_h_side;
            r_m_line <= r_h_line;
            r_m_neg  <= r_h_area[AREA_W-1];
            r_m_big  <= m_big;
            r_m_asq  <= ASQ_W'(m_abs[SQ_W-1:0]) * ASQ_W'(m_abs[SQ_W-1:0]);
            r_m_rhs  <= RHS_W'(r_h_msq) * RHS_W'(r_h_len2);
        end
    end

    // ------------------------------------------------------------------
    // Output register: pick the strategy; a bypassed grid reports a zero line.
    // A zero-length line has zero area and so falls to keep calm.
    // ------------------------------------------------------------------
    logic      o_beyond;
    t_strategy o_strat;
    logic [OUT_W-1:0] o_data;

    assign o_beyond = r_m_big || (CMP_W'(r_m_asq) > CMP_W'(r_m_rhs));

    always_comb begin
        priority if (r_m_side.byp) begin
            o_strat = r_m_side.strat;
        end else if (o_beyond) begin
            o_strat = r_m_neg ? STRAT_ATTACK : STRAT_DEFENCE;
        end else begin
            o_strat = STRAT_CALM;
        end
        o_data = '0;
        o_data[1:0] = o_strat;
        if (!r_m_side.byp) begin
            for (int cc = 0; cc < COMPS; cc++) begin
                o_data[2 + cc*C +: C] = r_m_line[cc];
            end
        end
    end

    logic [OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m_valid;
        end
        if (en) begin
            r_out_data <= o_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
